[sv/blsp_pkg.sv]
// blsp_pkg: shared widths, types and codes for the line stepper
// no dependencies; used by every module of the block
package blsp_pkg;

    localparam int COORD_BITS    = 10;
    localparam int ERR_BITS      = COORD_BITS + 2;
    localparam int COLOR_BITS    = 16;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic [COLOR_BITS-1:0]        color_t;
    typedef logic [FIFO_PTR_BITS-1:0]     fifo_ptr_t;
    typedef logic [FIFO_PTR_BITS:0]       fifo_cnt_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    // one classified item as it travels through the queue
    typedef struct packed {
        kind_t  kind;
        logic   steep;
        coord_t major_start;
        coord_t major_stop;
        coord_t minor_start;
        coord_t major_delta;
        coord_t minor_delta;
        logic   minor_down;
        color_t color;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

[sv/bresenham_line_stepper_top.sv]
// bresenham_line_stepper_top: line rasterizer top level
// depends on blsp_pkg, blsp_front, blsp_fifo, blsp_back
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+----------------
//  input   | in        | s_kind s_x_start s_y_start s_x_end s_y_end   | s_valid/s_ready
//          |           | s_draw_color                                 |
//  result  | out       | m_pixel_x m_pixel_y m_pixel_color m_last     | m_valid/m_ready
//
// one item per clock sustained while m_ready is high: the back end pops one queued item per cycle
// a pixel reaches the output register after its item is accepted and registered in the queue (queue, then output)
// a load yields its first pixel; a step on an idle line is consumed and yields nothing
// aresetn is synchronous, active low; it clears the queue, the line-active flag and m_valid
// output stalls back up through the two-entry queue; s_ready drops only when it is full
module bresenham_line_stepper_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  blsp_pkg::coord_t      s_x_start,
    input  blsp_pkg::coord_t      s_y_start,
    input  blsp_pkg::coord_t      s_x_end,
    input  blsp_pkg::coord_t      s_y_end,
    input  blsp_pkg::color_t      s_draw_color,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output blsp_pkg::coord_t      m_pixel_x,
    output blsp_pkg::coord_t      m_pixel_y,
    output blsp_pkg::color_t      m_pixel_color,
    output logic                  m_last
);

    // classified item from the front end and its queue handshake
    blsp_pkg::cmd_t       push_cmd;
    blsp_pkg::cmd_t       pop_cmd;
    logic                 push;
    logic                 pop;
    blsp_pkg::fifo_stat_t fifo_stat;

    // front: sorts endpoints, picks the major axis, computes deltas
    blsp_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_x_start    (s_x_start),
        .s_y_start    (s_y_start),
        .s_x_end      (s_x_end),
        .s_y_end      (s_y_end),
        .s_draw_color (s_draw_color),
        .fifo_stat    (fifo_stat),
        .push         (push),
        .cmd          (push_cmd)
    );

    // queue: lets the front keep accepting while the output is stalled
    blsp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (fifo_stat)
    );

    // back: holds the active line and the error term, emits pixels
    blsp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (pop_cmd),
        .fifo_stat     (fifo_stat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_pixel_color (m_pixel_color),
        .m_last        (m_last)
    );

endmodule

[sv/blsp_front.sv]
// blsp_front: accepts input items and works out the line setup for loads
// depends on blsp_pkg; feeds blsp_fifo
module blsp_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  blsp_pkg::coord_t      s_x_start,
    input  blsp_pkg::coord_t      s_y_start,
    input  blsp_pkg::coord_t      s_x_end,
    input  blsp_pkg::coord_t      s_y_end,
    input  blsp_pkg::color_t      s_draw_color,
    input  blsp_pkg::fifo_stat_t  fifo_stat,
    output logic                  push,
    output blsp_pkg::cmd_t        cmd
);

    blsp_pkg::coord_t adx, ady;
    blsp_pkg::coord_t ma, na, mb, nb;
    blsp_pkg::coord_t ma_o, na_o, mb_o, nb_o;
    logic             steep;
    logic             swap;

    assign s_ready = !fifo_stat.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        adx   = (s_x_end > s_x_start) ? s_x_end - s_x_start : s_x_start - s_x_end;
        ady   = (s_y_end > s_y_start) ? s_y_end - s_y_start : s_y_start - s_y_end;
        steep = ady > adx;
        if (steep) begin
            ma = s_y_start; na = s_x_start; mb = s_y_end; nb = s_x_end;
        end else begin
            ma = s_x_start; na = s_y_start; mb = s_x_end; nb = s_y_end;
        end
        // order endpoints so the major coordinate rises; equal keeps order
        swap = ma > mb;
        ma_o = swap ? mb : ma;
        mb_o = swap ? ma : mb;
        na_o = swap ? nb : na;
        nb_o = swap ? na : nb;

        cmd.kind        = blsp_pkg::kind_t'(s_kind);
        cmd.steep       = steep;
        cmd.major_start = ma_o;
        cmd.major_stop  = mb_o;
        cmd.minor_start = na_o;
        cmd.major_delta = mb_o - ma_o;
        cmd.minor_delta = (nb_o > na_o) ? nb_o - na_o : na_o - nb_o;
        cmd.minor_down  = !(na_o < nb_o);
        cmd.color       = s_draw_color;
    end

endmodule

[sv/blsp_fifo.sv]
// blsp_fifo: short queue of classified items between front and back
// depends on blsp_pkg
module blsp_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  blsp_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output blsp_pkg::cmd_t        pop_cmd,
    output blsp_pkg::fifo_stat_t  stat
);

    blsp_pkg::cmd_t      mem_reg [blsp_pkg::FIFO_DEPTH];
    blsp_pkg::fifo_ptr_t wr_ptr_reg, wr_ptr_next;
    blsp_pkg::fifo_ptr_t rd_ptr_reg, rd_ptr_next;
    blsp_pkg::fifo_cnt_t count_reg, count_next;

    localparam blsp_pkg::fifo_ptr_t PtrLast =
        blsp_pkg::FIFO_PTR_BITS'(blsp_pkg::FIFO_DEPTH - 1);
    localparam blsp_pkg::fifo_cnt_t CntFull =
        (blsp_pkg::FIFO_PTR_BITS + 1)'(blsp_pkg::FIFO_DEPTH);

    assign stat.full  = count_reg == CntFull;
    assign stat.empty = count_reg == '0;
    assign pop_cmd    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!stat.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntFull)
        else $error("queue count out of range");

endmodule

[sv/blsp_back.sv]
// blsp_back: walks the major axis, at most one pixel per queued item, into the output register
// depends on blsp_pkg; fed by blsp_fifo
module blsp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  blsp_pkg::cmd_t        cmd,
    input  blsp_pkg::fifo_stat_t  fifo_stat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output blsp_pkg::coord_t      m_pixel_x,
    output blsp_pkg::coord_t      m_pixel_y,
    output blsp_pkg::color_t      m_pixel_color,
    output logic                  m_last
);

    logic             active_reg, active_next;
    logic             steep_reg, steep_next;
    blsp_pkg::coord_t major_pos_reg, major_pos_next;
    blsp_pkg::coord_t major_stop_reg, major_stop_next;
    blsp_pkg::coord_t minor_pos_reg, minor_pos_next;
    blsp_pkg::err_t   err_reg, err_next;
    blsp_pkg::coord_t major_delta_reg, major_delta_next;
    blsp_pkg::coord_t minor_delta_reg, minor_delta_next;
    logic             minor_down_reg, minor_down_next;
    blsp_pkg::color_t color_reg, color_next;

    logic             m_valid_reg, m_valid_next;
    blsp_pkg::coord_t m_x_reg, m_x_next;
    blsp_pkg::coord_t m_y_reg, m_y_next;
    blsp_pkg::color_t m_color_reg, m_color_next;
    logic             m_last_reg, m_last_next;

    logic             is_load, do_emit, fin, err_neg;
    logic             cur_steep, cur_down;
    blsp_pkg::coord_t cur_major, cur_stop, cur_minor, cur_mjd, cur_mnd;
    blsp_pkg::color_t cur_color;
    blsp_pkg::err_t   cur_err, err_sub;

    assign pop     = !fifo_stat.empty && (!m_valid_reg || m_ready);
    assign is_load = cmd.kind == blsp_pkg::KIND_LOAD;
    assign do_emit = pop && (is_load || active_reg);

    always_comb begin
        cur_steep = is_load ? cmd.steep       : steep_reg;
        cur_major = is_load ? cmd.major_start : major_pos_reg;
        cur_stop  = is_load ? cmd.major_stop  : major_stop_reg;
        cur_minor = is_load ? cmd.minor_start : minor_pos_reg;
        cur_mjd   = is_load ? cmd.major_delta : major_delta_reg;
        cur_mnd   = is_load ? cmd.minor_delta : minor_delta_reg;
        cur_down  = is_load ? cmd.minor_down  : minor_down_reg;
        cur_color = is_load ? cmd.color       : color_reg;
        cur_err   = is_load ? blsp_pkg::err_t'({2'b00, cmd.major_delta >> 1}) : err_reg;

        fin     = cur_major == cur_stop;
        err_sub = cur_err - blsp_pkg::err_t'({2'b00, cur_mnd});
        err_neg = err_sub[blsp_pkg::ERR_BITS-1];
    end

    // next line state
    always_comb begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_stop_next  = major_stop_reg;
        minor_pos_next   = minor_pos_reg;
        err_next         = err_reg;
        major_delta_next = major_delta_reg;
        minor_delta_next = minor_delta_reg;
        minor_down_next  = minor_down_reg;
        color_next       = color_reg;
        if (do_emit) begin
            active_next      = !fin;
            steep_next       = cur_steep;
            major_pos_next   = cur_major + 1'b1;
            major_stop_next  = cur_stop;
            major_delta_next = cur_mjd;
            minor_delta_next = cur_mnd;
            minor_down_next  = cur_down;
            color_next       = cur_color;
            if (err_neg) begin
                minor_pos_next = cur_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
                err_next       = err_sub + blsp_pkg::err_t'({2'b00, cur_mjd});
            end else begin
                minor_pos_next = cur_minor;
                err_next       = err_sub;
            end
        end
    end

    // output register
    always_comb begin
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_color_next = m_color_reg;
        m_last_next  = m_last_reg;
        if (pop) begin
            m_valid_next = do_emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
        if (do_emit) begin
            m_x_next     = cur_steep ? cur_minor : cur_major;
            m_y_next     = cur_steep ? cur_major : cur_minor;
            m_color_next = cur_color;
            m_last_next  = fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steep_reg       <= steep_next;
        major_pos_reg   <= major_pos_next;
        major_stop_reg  <= major_stop_next;
        minor_pos_reg   <= minor_pos_next;
        err_reg         <= err_next;
        major_delta_reg <= major_delta_next;
        minor_delta_reg <= minor_delta_next;
        minor_down_reg  <= minor_down_next;
        color_reg       <= color_next;
        m_x_reg         <= m_x_next;
        m_y_reg         <= m_y_next;
        m_color_reg     <= m_color_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = m_x_reg;
    assign m_pixel_y     = m_y_reg;
    assign m_pixel_color = m_color_reg;
    assign m_last        = m_last_reg;

    a_pop_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!m_valid_reg || m_ready))
        else $error("queue drained while output register blocked");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> !active_reg)
        else $error("line still active after its final pixel");

    a_idle_step_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !is_load && !active_reg) |=> !m_valid_reg)
        else $error("step on idle line produced a pixel");

endmodule
